@@ hdl/fbl_pkg.sv @@
`timescale 1ns / 1ps

package fbl_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CENTERED_W = 17;
    localparam int FILT_W     = 18;
    localparam int Y_W        = 32;
    localparam int COEF_W     = 16;
    localparam int FB1_W      = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_BIAS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_2  = 3'd5;

    localparam logic signed [SAMPLE_W-1:0] BIAS_RESET = 16'sd515;
    localparam logic [COEF_W-1:0]          FF0_RESET  = 16'd10232;
    localparam logic [COEF_W-1:0]          FF1_RESET  = 16'd20463;
    localparam logic [COEF_W-1:0]          FF2_RESET  = 16'd10232;
    localparam logic [FB1_W-1:0]           FB1_RESET  = 17'd63208;
    localparam logic [COEF_W-1:0]          FB2_RESET  = 16'd30520;

    localparam int SCALE_DEFAULT    = 200;
    localparam int FF_SHIFT_DEFAULT = 24;
    localparam int FB_SHIFT_DEFAULT = 15;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] input_bias;
        logic [COEF_W-1:0]          ff_coef_0;
        logic [COEF_W-1:0]          ff_coef_1;
        logic [COEF_W-1:0]          ff_coef_2;
        logic [FB1_W-1:0]           fb_coef_1;
        logic [COEF_W-1:0]          fb_coef_2;
    } cfg_t;

endpackage

@@ hdl/fbl_cfg_regs.sv @@
`timescale 1ns / 1ps

module fbl_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fbl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbl_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fbl_pkg::cfg_t                    cfg
);

    fbl_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                fbl_pkg::REG_INPUT_BIAS: cfg_next.input_bias = cfg_data[fbl_pkg::SAMPLE_W-1:0];
                fbl_pkg::REG_FF_COEF_0:  cfg_next.ff_coef_0  = cfg_data[fbl_pkg::COEF_W-1:0];
                fbl_pkg::REG_FF_COEF_1:  cfg_next.ff_coef_1  = cfg_data[fbl_pkg::COEF_W-1:0];
                fbl_pkg::REG_FF_COEF_2:  cfg_next.ff_coef_2  = cfg_data[fbl_pkg::COEF_W-1:0];
                fbl_pkg::REG_FB_COEF_1:  cfg_next.fb_coef_1  = cfg_data[fbl_pkg::FB1_W-1:0];
                fbl_pkg::REG_FB_COEF_2:  cfg_next.fb_coef_2  = cfg_data[fbl_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.input_bias <= fbl_pkg::BIAS_RESET;
            cfg_reg.ff_coef_0  <= fbl_pkg::FF0_RESET;
            cfg_reg.ff_coef_1  <= fbl_pkg::FF1_RESET;
            cfg_reg.ff_coef_2  <= fbl_pkg::FF2_RESET;
            cfg_reg.fb_coef_1  <= fbl_pkg::FB1_RESET;
            cfg_reg.fb_coef_2  <= fbl_pkg::FB2_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/fixed_point_biquad_lowpass_unit.sv @@
`timescale 1ns / 1ps

// Biquad low-pass (direct form I) on a signed sample stream. One sample per clock is
// accepted while the output side is not stalled; each sample's result is registered at every
// stage, and a stalled output lets earlier stages keep filling. The sample rate
// is set by the feedback stage, which forms both feedback products and the new output
// combinationally. Division by SCALE uses a reciprocal multiply with one correction step.
// Register writes are taken on any cycle (cfg_ready is tied high) and must only be issued
// while no sample is in flight.
module fixed_point_biquad_lowpass_unit #(
    parameter int SCALE            = fbl_pkg::SCALE_DEFAULT,
    parameter int FF_DIVISOR_SHIFT = fbl_pkg::FF_SHIFT_DEFAULT,
    parameter int FB_DIVISOR_SHIFT = fbl_pkg::FB_SHIFT_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [fbl_pkg::SAMPLE_W-1:0]    s_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [fbl_pkg::CENTERED_W-1:0]  m_centered_sample,
    output logic signed [fbl_pkg::FILT_W-1:0]      m_filtered_value,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fbl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [fbl_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int CW       = fbl_pkg::CENTERED_W;
    localparam int YW       = fbl_pkg::Y_W;
    localparam int FW       = fbl_pkg::FILT_W;
    localparam int N_STG    = 8;
    localparam int CTR_MAX  = 2**(CW-1) - 1;
    localparam int SCALED_W = $clog2(CTR_MAX*SCALE + 1) + 1;
    localparam int FFP_W    = SCALED_W + fbl_pkg::COEF_W + 1;
    localparam int FFT_W    = FFP_W - FF_DIVISOR_SHIFT;
    localparam int FFS_W    = FFT_W + 2;
    localparam int FBP_W    = YW + fbl_pkg::FB1_W + 1;
    localparam int FBT_W    = FBP_W - FB_DIVISOR_SHIFT;
    localparam int ACC_W    = FBP_W + 2;
    localparam int SAT_MAG  = (2**(FW-1)) * SCALE;
    localparam int MAG_W    = $clog2(SAT_MAG + 1);
    localparam int DIV_K    = MAG_W;
    localparam int RECIP    = (2**DIV_K) / SCALE;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int PR_W     = MAG_W + RECIP_W;
    localparam int QM_W     = RECIP_W + 1;

    localparam logic signed [SCALED_W-1:0] SCALE_S  = SCALED_W'(SCALE);
    localparam logic [FFP_W-1:0]           FF_RND   = FFP_W'((2**FF_DIVISOR_SHIFT) - 1);
    localparam logic [FBP_W-1:0]           FB_RND   = FBP_W'((2**FB_DIVISOR_SHIFT) - 1);
    localparam logic signed [ACC_W-1:0]    Y_MAX_A  = ACC_W'({1'b0, {(YW-1){1'b1}}});
    localparam logic signed [ACC_W-1:0]    Y_MIN_A  = ~Y_MAX_A;
    localparam logic [YW-1:0]              SAT_Y    = YW'(SAT_MAG);
    localparam logic [MAG_W-1:0]           SAT_M    = MAG_W'(SAT_MAG);
    localparam logic [PR_W-1:0]            RECIP_P  = PR_W'(RECIP);
    localparam logic [PR_W-1:0]            SCALE_P  = PR_W'(SCALE);
    localparam logic [MAG_W-1:0]           SCALE_M  = MAG_W'(SCALE);
    localparam logic [QM_W-1:0]            FILT_LIM = QM_W'(2**(FW-1));
    localparam logic signed [FW-1:0]       FILT_MAX = {1'b0, {(FW-1){1'b1}}};
    localparam logic signed [FW-1:0]       FILT_MIN = {1'b1, {(FW-1){1'b0}}};

    fbl_pkg::cfg_t cfg;

    fbl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pipeline flow control
    logic [N_STG-1:0] v_reg, v_next, free, load;
    logic [N_STG-2:0] leave;

    always_comb begin
        free[N_STG-1]  = ~v_reg[N_STG-1] | m_ready;
        for (int i = N_STG-2; i >= 0; i--) begin
            leave[i] = v_reg[i] & free[i+1];
            free[i]  = ~v_reg[i] | free[i+1];
        end
        load[0] = s_valid & free[0];
        for (int i = 1; i < N_STG; i++) begin
            load[i] = leave[i-1];
        end
        for (int i = 0; i < N_STG; i++) begin
            v_next[i] = free[i] ? load[i] : v_reg[i];
        end
    end

    assign s_ready = free[0];
    assign m_valid = v_reg[N_STG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // centered sample travels with its item
    logic signed [CW-1:0] c_reg [N_STG];
    logic signed [CW-1:0] c0_next;

    assign c0_next = CW'(s_sample) - CW'(cfg.input_bias);

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            c_reg[0] <= c0_next;
        end
        for (int i = 1; i < N_STG; i++) begin
            if (load[i]) begin
                c_reg[i] <= c_reg[i-1];
            end
        end
    end

    // stage 1: scale and input history
    logic signed [SCALED_W-1:0] x0_reg, x1_reg, x2_reg, x0_next;
    logic signed [SCALED_W-1:0] prev_in_reg, prev2_in_reg;

    assign x0_next = SCALED_W'(c_reg[0]) * SCALE_S;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_in_reg  <= '0;
            prev2_in_reg <= '0;
        end else if (load[1]) begin
            prev_in_reg  <= x0_next;
            prev2_in_reg <= prev_in_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            x0_reg <= x0_next;
            x1_reg <= prev_in_reg;
            x2_reg <= prev2_in_reg;
        end
    end

    // stage 2: feed-forward products
    logic signed [FFP_W-1:0] ffp_reg [3];
    logic signed [FFP_W-1:0] ffp_next [3];

    always_comb begin
        ffp_next[0] = FFP_W'(x0_reg) * FFP_W'($signed({1'b0, cfg.ff_coef_0}));
        ffp_next[1] = FFP_W'(x1_reg) * FFP_W'($signed({1'b0, cfg.ff_coef_1}));
        ffp_next[2] = FFP_W'(x2_reg) * FFP_W'($signed({1'b0, cfg.ff_coef_2}));
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            ffp_reg <= ffp_next;
        end
    end

    // stage 3: truncate toward zero and sum
    logic signed [FFP_W-1:0] ffr [3];
    logic signed [FFT_W-1:0] fft [3];
    logic signed [FFS_W-1:0] ffsum_reg, ffsum_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ffr[i] = ffp_reg[i] + (ffp_reg[i][FFP_W-1] ? FF_RND : '0);
            fft[i] = ffr[i][FFP_W-1:FF_DIVISOR_SHIFT];
        end
        ffsum_next = FFS_W'(fft[0]) + FFS_W'(fft[1]) + FFS_W'(fft[2]);
    end

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            ffsum_reg <= ffsum_next;
        end
    end

    // stage 4: feedback recursion, output history doubles as the stage register
    logic signed [YW-1:0]    prev_out_reg, prev2_out_reg, y_next;
    logic signed [FBP_W-1:0] fbp1, fbp2, fbr1, fbr2;
    logic signed [FBT_W-1:0] fbt1, fbt2;
    logic signed [ACC_W-1:0] acc;

    always_comb begin
        fbp1 = FBP_W'(prev_out_reg) * FBP_W'($signed({1'b0, cfg.fb_coef_1}));
        fbp2 = FBP_W'(prev2_out_reg) * FBP_W'($signed({1'b0, cfg.fb_coef_2}));
        fbr1 = fbp1 + (fbp1[FBP_W-1] ? FB_RND : '0);
        fbr2 = fbp2 + (fbp2[FBP_W-1] ? FB_RND : '0);
        fbt1 = fbr1[FBP_W-1:FB_DIVISOR_SHIFT];
        fbt2 = fbr2[FBP_W-1:FB_DIVISOR_SHIFT];
        acc  = ACC_W'(ffsum_reg) + ACC_W'(fbt1) - ACC_W'(fbt2);
        if (acc > Y_MAX_A) begin
            y_next = Y_MAX_A[YW-1:0];
        end else if (acc < Y_MIN_A) begin
            y_next = Y_MIN_A[YW-1:0];
        end else begin
            y_next = acc[YW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_out_reg  <= '0;
            prev2_out_reg <= '0;
        end else if (load[4]) begin
            prev_out_reg  <= y_next;
            prev2_out_reg <= prev_out_reg;
        end
    end

    // stage 5: magnitude, pre-saturation, reciprocal multiply
    logic             neg5_reg, neg5_next;
    logic [YW-1:0]    mag_full;
    logic [MAG_W-1:0] mag5_reg, mag5_next;
    logic [PR_W-1:0]  prod_reg, prod_next;

    always_comb begin
        neg5_next = prev_out_reg[YW-1];
        mag_full  = neg5_next ? YW'(-prev_out_reg) : YW'(prev_out_reg);
        mag5_next = (mag_full > SAT_Y) ? SAT_M : mag_full[MAG_W-1:0];
        prod_next = PR_W'(mag5_next) * RECIP_P;
    end

    always_ff @(posedge aclk) begin
        if (load[5]) begin
            neg5_reg <= neg5_next;
            mag5_reg <= mag5_next;
            prod_reg <= prod_next;
        end
    end

    // stage 6: quotient estimate and back-multiply
    logic               neg6_reg;
    logic [MAG_W-1:0]   mag6_reg, qd_reg, qd_next;
    logic [RECIP_W-1:0] qe_reg, qe_next;
    logic [PR_W-1:0]    qd_full;

    always_comb begin
        qe_next = prod_reg[PR_W-1:DIV_K];
        qd_full = PR_W'(qe_next) * SCALE_P;
        qd_next = qd_full[MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (load[6]) begin
            neg6_reg <= neg5_reg;
            mag6_reg <= mag5_reg;
            qe_reg   <= qe_next;
            qd_reg   <= qd_next;
        end
    end

    // stage 7: correction, sign and saturation
    logic [MAG_W-1:0]     rem;
    logic [QM_W-1:0]      qm;
    logic signed [FW-1:0] filt_reg, filt_next;

    always_comb begin
        rem = mag6_reg - qd_reg;
        qm  = QM_W'(qe_reg) + ((rem >= SCALE_M) ? QM_W'(1) : QM_W'(0));
        if (neg6_reg) begin
            filt_next = (qm >= FILT_LIM) ? FILT_MIN : -$signed(qm[FW-1:0]);
        end else begin
            filt_next = (qm >= FILT_LIM) ? FILT_MAX : $signed(qm[FW-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (load[7]) begin
            filt_reg <= filt_next;
        end
    end

    assign m_centered_sample = c_reg[N_STG-1];
    assign m_filtered_value  = filt_reg;

endmodule

@@ tb/fixed_point_biquad_lowpass_unit_test.sv @@
`timescale 1ns / 1ps

module fixed_point_biquad_lowpass_unit_test;

    localparam int SAMPLE_W   = fbl_pkg::SAMPLE_W;
    localparam int CENTERED_W = fbl_pkg::CENTERED_W;
    localparam int FILT_W     = fbl_pkg::FILT_W;
    localparam int COEF_W     = fbl_pkg::COEF_W;
    localparam int FB1_W      = fbl_pkg::FB1_W;
    localparam int CFG_IDX_W  = fbl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = fbl_pkg::CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = 3'd7;

    localparam longint SCALE_L  = fbl_pkg::SCALE_DEFAULT;
    localparam longint FF_DIV   = 64'sd1 <<< fbl_pkg::FF_SHIFT_DEFAULT;
    localparam longint FB_DIV   = 64'sd1 <<< fbl_pkg::FB_SHIFT_DEFAULT;
    localparam longint Y_MAX    = 64'sd2147483647;
    localparam longint Y_MIN    = -64'sd2147483648;
    localparam longint FILT_MAX = 64'sd131071;
    localparam longint FILT_MIN = -64'sd131072;
    localparam int     HOLD_CYCLES = 80;

    typedef struct {
        logic signed [CENTERED_W-1:0] centered;
        logic signed [FILT_W-1:0]     filtered;
    } biquad_out_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_W-1:0]    s_sample = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [CENTERED_W-1:0]  m_centered_sample;
    logic signed [FILT_W-1:0]      m_filtered_value;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    fbl_pkg::cfg_t coefs;
    longint      hist_in_1, hist_in_2, hist_out_1, hist_out_2;
    biquad_out_t expected_outputs[$];
    int          mismatches = 0;
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;
    logic signed [SAMPLE_W-1:0] last_sample = '0;

    fixed_point_biquad_lowpass_unit u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample          (s_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_centered_sample (m_centered_sample),
        .m_filtered_value  (m_filtered_value),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("fixed_point_biquad_lowpass_unit_test NOT OK");
        $finish;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic biquad_out_t biquad_predict(logic signed [SAMPLE_W-1:0] x);
        longint      centered, scaled, y, q;
        biquad_out_t r;
        centered = longint'(x) - longint'($signed(coefs.input_bias));
        scaled   = centered * SCALE_L;
        y = (scaled * longint'(coefs.ff_coef_0)) / FF_DIV
          + (hist_in_1 * longint'(coefs.ff_coef_1)) / FF_DIV
          + (hist_in_2 * longint'(coefs.ff_coef_2)) / FF_DIV
          + (hist_out_1 * longint'(coefs.fb_coef_1)) / FB_DIV
          - (hist_out_2 * longint'(coefs.fb_coef_2)) / FB_DIV;
        y = clamp(y, Y_MIN, Y_MAX);
        hist_in_2  = hist_in_1;
        hist_in_1  = scaled;
        hist_out_2 = hist_out_1;
        hist_out_1 = y;
        q = clamp(y / SCALE_L, FILT_MIN, FILT_MAX);
        r.centered = centered[CENTERED_W-1:0];
        r.filtered = q[FILT_W-1:0];
        return r;
    endfunction

    task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_outputs.push_back(biquad_predict(x));
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            fbl_pkg::REG_INPUT_BIAS: coefs.input_bias = data[SAMPLE_W-1:0];
            fbl_pkg::REG_FF_COEF_0:  coefs.ff_coef_0  = data[COEF_W-1:0];
            fbl_pkg::REG_FF_COEF_1:  coefs.ff_coef_1  = data[COEF_W-1:0];
            fbl_pkg::REG_FF_COEF_2:  coefs.ff_coef_2  = data[COEF_W-1:0];
            fbl_pkg::REG_FB_COEF_1:  coefs.fb_coef_1  = data[FB1_W-1:0];
            fbl_pkg::REG_FB_COEF_2:  coefs.fb_coef_2  = data[COEF_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // spare top bit on the 16-bit registers is randomised; it must be dropped
    task automatic write_config(fbl_pkg::cfg_t c);
        write_register(fbl_pkg::REG_INPUT_BIAS, {1'($urandom_range(0, 1)), c.input_bias});
        write_register(fbl_pkg::REG_FF_COEF_0,  {1'($urandom_range(0, 1)), c.ff_coef_0});
        write_register(fbl_pkg::REG_FF_COEF_1,  {1'($urandom_range(0, 1)), c.ff_coef_1});
        write_register(fbl_pkg::REG_FF_COEF_2,  {1'($urandom_range(0, 1)), c.ff_coef_2});
        write_register(fbl_pkg::REG_FB_COEF_1,  c.fb_coef_1);
        write_register(fbl_pkg::REG_FB_COEF_2,  {1'($urandom_range(0, 1)), c.fb_coef_2});
    endtask

    function automatic fbl_pkg::cfg_t reset_config();
        fbl_pkg::cfg_t c;
        c.input_bias = fbl_pkg::BIAS_RESET;
        c.ff_coef_0  = fbl_pkg::FF0_RESET;
        c.ff_coef_1  = fbl_pkg::FF1_RESET;
        c.ff_coef_2  = fbl_pkg::FF2_RESET;
        c.fb_coef_1  = fbl_pkg::FB1_RESET;
        c.fb_coef_2  = fbl_pkg::FB2_RESET;
        return c;
    endfunction

    function automatic fbl_pkg::cfg_t random_config();
        fbl_pkg::cfg_t c;
        c = reset_config();
        case ($urandom_range(0, 3))
            0: c.input_bias = SAMPLE_W'($urandom);
            1: begin
                c.input_bias = SAMPLE_W'($urandom);
                c.ff_coef_0  = COEF_W'($urandom);
                c.ff_coef_1  = COEF_W'($urandom);
                c.ff_coef_2  = COEF_W'($urandom);
                c.fb_coef_1  = FB1_W'($urandom);
                c.fb_coef_2  = COEF_W'($urandom);
            end
            2: begin
                c.input_bias = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                c.ff_coef_0  = $urandom_range(0, 1) ? '1 : '0;
                c.ff_coef_1  = $urandom_range(0, 1) ? '1 : '0;
                c.ff_coef_2  = $urandom_range(0, 1) ? '1 : '0;
                c.fb_coef_1  = $urandom_range(0, 1) ? '1 : '0;
                c.fb_coef_2  = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                c.input_bias = SAMPLE_W'($urandom_range(0, 2000) - 1000);
                c.ff_coef_0  = COEF_W'($urandom_range(0, 30000));
                c.ff_coef_1  = COEF_W'($urandom_range(0, 30000));
                c.ff_coef_2  = COEF_W'($urandom_range(0, 30000));
                c.fb_coef_1  = FB1_W'($urandom_range(0, 65535));
                c.fb_coef_2  = COEF_W'($urandom_range(0, 32767));
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: last_sample = SAMPLE_W'($urandom);
            6: begin
                case ($urandom_range(0, 3))
                    0: last_sample = 16'sh8000;
                    1: last_sample = 16'sh7FFF;
                    2: last_sample = '0;
                    default: last_sample = '1;
                endcase
            end
            default: last_sample = last_sample + SAMPLE_W'($urandom_range(0, 512) - 256);
        endcase
        return last_sample;
    endfunction

    task automatic wait_idle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (expected_outputs.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_outputs.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_outputs.size());
            mismatches++;
            expected_outputs.delete();
        end
        repeat (12) @(posedge aclk);
    endtask

    task automatic run_random(int n);
        repeat (n) send_sample(random_sample());
        wait_idle();
    endtask

    // result checker
    always @(posedge aclk) begin
        biquad_out_t exp_out;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                $display("%0t: unexpected result centered %0d filtered %0d", $time,
                         m_centered_sample, m_filtered_value);
                mismatches++;
            end else begin
                exp_out = expected_outputs.pop_front();
                if (m_centered_sample !== exp_out.centered) begin
                    $display("%0t: centered_sample expected %0d got %0d", $time,
                             exp_out.centered, m_centered_sample);
                    mismatches++;
                end
                if (m_filtered_value !== exp_out.filtered) begin
                    $display("%0t: filtered_value expected %0d got %0d", $time,
                             exp_out.filtered, m_filtered_value);
                    mismatches++;
                end
            end
        end
    end

    // receiver: short random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req || hold_left > 0) begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic test_reset_values();
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        wait_idle();
    endtask

    // drives the output into both the 32-bit and the 18-bit clamps, each sign
    task automatic test_saturation();
        fbl_pkg::cfg_t c;
        c.input_bias = 16'sh8000;
        c.ff_coef_0  = '1;
        c.ff_coef_1  = '1;
        c.ff_coef_2  = '1;
        c.fb_coef_1  = '1;
        c.fb_coef_2  = '0;
        write_config(c);
        repeat (12) send_sample(16'sh7FFF);
        wait_idle();
        c.input_bias = 16'sh7FFF;
        c.fb_coef_1  = '0;
        c.fb_coef_2  = '1;
        write_config(c);
        repeat (4) send_sample(16'sh8000);
        wait_idle();
    endtask

    task automatic test_spare_index();
        write_config(reset_config());
        write_register(REG_SPARE_0, '1);
        write_register(REG_SPARE_1, CFG_DATA_W'($urandom));
        send_sample(16'sh1234);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        wait_idle();
    endtask

    task automatic test_zero_coefs();
        fbl_pkg::cfg_t c;
        c = '0;
        c.input_bias = 16'sh7FFF;
        write_config(c);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_config(reset_config());
        hold_req = 1'b1;
        run_random(40);
    endtask

    task automatic test_random_configs();
        repeat (7) begin
            write_config(random_config());
            if ($urandom_range(0, 1))
                write_register($urandom_range(0, 1) ? REG_SPARE_0 : REG_SPARE_1,
                               CFG_DATA_W'($urandom));
            run_random(100);
        end
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        write_config(reset_config());
        run_random(150);
    endtask

    initial begin
        coefs      = reset_config();
        hist_in_1  = 0;
        hist_in_2  = 0;
        hist_out_1 = 0;
        hist_out_2 = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_saturation();
        test_spare_index();
        test_zero_coefs();
        test_backpressure();
        test_random_configs();
        test_full_rate();

        if (mismatches == 0) begin
            $display("fixed_point_biquad_lowpass_unit_test OK");
        end else begin
            $display("fixed_point_biquad_lowpass_unit_test NOT OK");
        end
        $finish;
    end

endmodule
